>>> design/cpq_pkg.sv
// Shared types, register indexes and widths for the coin pulse qualifier and emitter.
package cpq_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned MS_W       = 10;
    localparam int unsigned BLANK_W    = 12;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned PEND_W     = 16;
    localparam int unsigned REQ_W      = 4;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 72;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH_MIN   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH_MAX   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HACK_GAP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_EMIT_PERIOD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_LEVEL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLANK       = 3'd5;

    // Reset values of the registers
    localparam logic [MS_W-1:0]    RST_WIDTH_MIN   = 10'd20;
    localparam logic [MS_W-1:0]    RST_WIDTH_MAX   = 10'd120;
    localparam logic [MS_W-1:0]    RST_HACK_GAP    = 10'd60;
    localparam logic [MS_W-1:0]    RST_EMIT_PERIOD = 10'd50;
    localparam logic               RST_START_LEVEL = 1'b0;
    localparam logic [BLANK_W-1:0] RST_BLANK       = 12'd1000;

    // Output line levels after reset: la 0, ha 1, watch 0 (bit 0 is la)
    localparam logic [2:0] RST_LINES = 3'b010;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    typedef struct packed {
        logic [MS_W-1:0]    width_min_ms;
        logic [MS_W-1:0]    width_max_ms;
        logic [MS_W-1:0]    hack_gap_min_ms;
        logic [MS_W-1:0]    emit_period_ms;
        logic               start_level;
        logic [BLANK_W-1:0] startup_blank_ms;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] hack_total;
        logic [CNT_W-1:0] coin_total;
        logic             hack_seen;
        logic             coin_accepted;
        logic             out_watch;
        logic             out_ha;
        logic             out_la;
    } t_result;

endpackage

>>> design/coin_pulse_qualifier_emitter.sv
// Top level: stream handshake, input and result registers around the tick core.
// Requests pass the input register, then the core, then the result register.
// Throughput: one tick request per clock cycle unless the result stream stalls; the
// core computes each result combinationally between the input and result registers.
// Reset (synchronous, active low) restores register defaults, clears time,
// counters and the toggle queue, and sets lines to la 0, ha 1, watch 0.
module coin_pulse_qualifier_emitter
    import cpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // tick request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [0] coin_in, [4:1] coin_request
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // [0] out_la, [1] out_ha, [2] out_watch,
                                               // [3] coin_accepted, [4] hack_seen,
                                               // [36:5] coin_total, [68:37] hack_total
);

    t_cfg             cfg;
    t_result          result;

    logic             r_in_valid;
    logic             r_coin_in;
    logic [REQ_W-1:0] r_coin_request;
    logic             r_out_valid;
    t_result          r_out;
    logic             advance;
    logic             step;

    cpq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cpq_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_coin_in      (r_coin_in),
        .i_coin_request (r_coin_request),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    // Move the pipe when the result slot is free or being drained
    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_coin_in      <= i_s_tdata[0];
            r_coin_request <= i_s_tdata[REQ_W:1];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-$bits(t_result)){1'b0}}, r_out};

endmodule

>>> design/cpq_cfg.sv
// Configuration register file for the coin pulse qualifier.
module cpq_cfg
    import cpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Decode the write index; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_min_ms     <= RST_WIDTH_MIN;
            r_cfg.width_max_ms     <= RST_WIDTH_MAX;
            r_cfg.hack_gap_min_ms  <= RST_HACK_GAP;
            r_cfg.emit_period_ms   <= RST_EMIT_PERIOD;
            r_cfg.start_level      <= RST_START_LEVEL;
            r_cfg.startup_blank_ms <= RST_BLANK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WIDTH_MIN:   r_cfg.width_min_ms     <= i_cfg_wdata[MS_W-1:0];
                CFG_WIDTH_MAX:   r_cfg.width_max_ms     <= i_cfg_wdata[MS_W-1:0];
                CFG_HACK_GAP:    r_cfg.hack_gap_min_ms  <= i_cfg_wdata[MS_W-1:0];
                CFG_EMIT_PERIOD: r_cfg.emit_period_ms   <= i_cfg_wdata[MS_W-1:0];
                CFG_START_LEVEL: r_cfg.start_level      <= i_cfg_wdata[0];
                CFG_BLANK:       r_cfg.startup_blank_ms <= i_cfg_wdata[BLANK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/cpq_core.sv
// Per-tick pulse qualification, hack detection, toggle queue and emit timer.
module cpq_core
    import cpq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_coin_in,
    input  logic [REQ_W-1:0] i_coin_request,
    input  t_cfg             i_cfg,
    output t_result          o_result
);

    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_stamp;
    logic              r_prev;
    logic [PEND_W-1:0] r_pending;
    logic [MS_W-1:0]   r_period;
    logic [2:0]        r_lines;
    logic [CNT_W-1:0]  r_coins;
    logic [CNT_W-1:0]  r_hacks;

    logic [TIME_W-1:0] n_stamp;
    logic [PEND_W-1:0] n_pending;
    logic [MS_W-1:0]   n_period;
    logic [2:0]        n_lines;
    logic [CNT_W-1:0]  n_coins;
    logic [CNT_W-1:0]  n_hacks;

    logic              armed;
    logic              edge_seen;
    logic              start_edge;
    logic [TIME_W-1:0] elapsed;
    logic              hack;
    logic              accept;
    logic [PEND_W+1:0] pend_sum;
    logic [PEND_W-1:0] pend_sat;
    logic [MS_W:0]     period_inc;
    logic              fire;

    // Qualify edges against the blank, gap and width window
    always_comb begin
        armed      = r_now >= {{(TIME_W-BLANK_W){1'b0}}, i_cfg.startup_blank_ms};
        edge_seen  = armed && (i_coin_in != r_prev);
        start_edge = i_coin_in == i_cfg.start_level;
        elapsed    = r_now - r_stamp;
        hack       = edge_seen && start_edge &&
                     (elapsed < {{(TIME_W-MS_W){1'b0}}, i_cfg.hack_gap_min_ms});
        accept     = edge_seen && !start_edge &&
                     (elapsed > {{(TIME_W-MS_W){1'b0}}, i_cfg.width_min_ms}) &&
                     (elapsed < {{(TIME_W-MS_W){1'b0}}, i_cfg.width_max_ms});
        n_stamp    = (edge_seen && start_edge) ? r_now : r_stamp;
        n_coins    = r_coins + {{(CNT_W-1){1'b0}}, accept};
        n_hacks    = r_hacks + {{(CNT_W-1){1'b0}}, hack};
    end

    // Add queued toggles with saturation, then run the emit timer
    always_comb begin
        pend_sum   = {2'b00, r_pending}
                   + {{(PEND_W-REQ_W+1){1'b0}}, i_coin_request, 1'b0}
                   + {{PEND_W{1'b0}}, accept, 1'b0};
        pend_sat   = (pend_sum > {2'b00, PEND_MAX}) ? PEND_MAX : pend_sum[PEND_W-1:0];
        period_inc = {1'b0, r_period} + {{MS_W{1'b0}}, 1'b1};
        fire       = period_inc >= {1'b0, i_cfg.emit_period_ms};
        n_period   = fire ? '0 : period_inc[MS_W-1:0];
        n_pending  = pend_sat;
        n_lines    = r_lines;
        if (fire && (pend_sat != '0)) begin
            n_pending = pend_sat - {{(PEND_W-1){1'b0}}, 1'b1};
            n_lines   = ~r_lines;
        end
    end

    // Hold state; advance once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_stamp   <= '0;
            r_prev    <= ~RST_START_LEVEL;
            r_pending <= '0;
            r_period  <= '0;
            r_lines   <= RST_LINES;
            r_coins   <= '0;
            r_hacks   <= '0;
        end else if (i_step) begin
            r_now     <= r_now + {{(TIME_W-1){1'b0}}, 1'b1};
            r_stamp   <= n_stamp;
            r_prev    <= i_coin_in;
            r_pending <= n_pending;
            r_period  <= n_period;
            r_lines   <= n_lines;
            r_coins   <= n_coins;
            r_hacks   <= n_hacks;
        end
    end

    assign o_result.hack_total    = n_hacks;
    assign o_result.coin_total    = n_coins;
    assign o_result.hack_seen     = hack;
    assign o_result.coin_accepted = accept;
    assign o_result.out_watch     = n_lines[2];
    assign o_result.out_ha        = n_lines[1];
    assign o_result.out_la        = n_lines[0];

    // A tick never both starts and ends a pulse
    a_no_hack_and_coin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(hack && accept)) else $error("hack and coin on the same tick");

    // An accepted coin leaves at least one toggle queued
    a_coin_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && accept |=> r_pending != '0) else $error("coin did not queue toggles");

    // The three lines always move together
    a_lines_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lines[0] == r_lines[2]) && (r_lines[1] != r_lines[0]))
        else $error("output lines out of step");

    // Time advances by one on every tick
    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_now == $past(r_now) + 32'd1) else $error("tick time did not advance");

endmodule

>>> tb/cpq_tick_checker.sv
// Scoreboard for the coin pulse qualifier: mirrors config, predicts each tick and compares.
module cpq_tick_checker
    import cpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [0] coin_in, [4:1] coin_request
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // [0] out_la, [1] out_ha, [2] out_watch,
                                               // [3] coin_accepted, [4] hack_seen,
                                               // [36:5] coin_total, [68:37] hack_total
    output logic [31:0]           o_due_count,
    output logic [31:0]           o_fail_count
);

    // Shadow registers and tick state
    t_cfg              regs;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] start_stamp;
    logic              prev_level;
    logic [PEND_W-1:0] toggles_pending;
    logic [MS_W-1:0]   period_cnt;
    logic [2:0]        lines;
    logic [CNT_W-1:0]  coins_seen;
    logic [CNT_W-1:0]  hacks_seen;

    t_result           tick_results_due[$];
    t_result           want_r;
    t_result           got_r;
    int unsigned       fails = 0;

    // Add toggles to the queue, clamp at the counter ceiling
    function automatic logic [PEND_W-1:0] add_toggles(input logic [PEND_W-1:0] base,
                                                      input logic [5:0] n);
        logic [PEND_W:0] sum;
        sum = {1'b0, base} + n;
        return (sum > PEND_MAX) ? PEND_MAX : sum[PEND_W-1:0];
    endfunction

    // Advance one millisecond tick and build the result it produces
    task automatic qualify_tick(input logic coin_in, input logic [REQ_W-1:0] req,
                                output t_result r);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] elapsed;
        t = now_ms;
        r = '0;
        // edges count only once the startup blank has passed
        if (t >= regs.startup_blank_ms && coin_in != prev_level) begin
            elapsed = t - start_stamp;
            if (coin_in == regs.start_level) begin
                if (elapsed < regs.hack_gap_min_ms) begin
                    r.hack_seen = 1'b1;
                    hacks_seen  = hacks_seen + 1'b1;
                end
                start_stamp = t;
            end else if (elapsed > regs.width_min_ms && elapsed < regs.width_max_ms) begin
                r.coin_accepted = 1'b1;
                coins_seen      = coins_seen + 1'b1;
                toggles_pending = add_toggles(toggles_pending, 6'd2);
            end
        end
        prev_level      = coin_in;
        toggles_pending = add_toggles(toggles_pending, {1'b0, req, 1'b0});
        // emit timer: a period of zero fires every tick, like one
        if (period_cnt + 32'd1 >= regs.emit_period_ms) begin
            period_cnt = '0;
            if (toggles_pending != '0) begin
                lines           = lines ^ 3'b111;
                toggles_pending = toggles_pending - 1'b1;
            end
        end else begin
            period_cnt = period_cnt + 1'b1;
        end
        now_ms          = t + 1'b1;
        r.out_la        = lines[0];
        r.out_ha        = lines[1];
        r.out_watch     = lines[2];
        r.coin_total    = coins_seen;
        r.hack_total    = hacks_seen;
    endtask

    task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.width_min_ms     = RST_WIDTH_MIN;
            regs.width_max_ms     = RST_WIDTH_MAX;
            regs.hack_gap_min_ms  = RST_HACK_GAP;
            regs.emit_period_ms   = RST_EMIT_PERIOD;
            regs.start_level      = RST_START_LEVEL;
            regs.startup_blank_ms = RST_BLANK;
            now_ms                = '0;
            start_stamp           = '0;
            prev_level            = ~RST_START_LEVEL;
            toggles_pending       = '0;
            period_cnt            = '0;
            lines                 = RST_LINES;
            coins_seen            = '0;
            hacks_seen            = '0;
            tick_results_due.delete();
        end else begin
            // mirror register writes; start level leaves the previous pin level alone
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WIDTH_MIN:   regs.width_min_ms     = i_cfg_wdata[MS_W-1:0];
                    CFG_WIDTH_MAX:   regs.width_max_ms     = i_cfg_wdata[MS_W-1:0];
                    CFG_HACK_GAP:    regs.hack_gap_min_ms  = i_cfg_wdata[MS_W-1:0];
                    CFG_EMIT_PERIOD: regs.emit_period_ms   = i_cfg_wdata[MS_W-1:0];
                    CFG_START_LEVEL: regs.start_level      = i_cfg_wdata[0];
                    CFG_BLANK:       regs.startup_blank_ms = i_cfg_wdata[BLANK_W-1:0];
                    default: ;
                endcase
            end
            // compare a delivered result with the oldest one due
            if (i_m_tvalid && i_m_tready) begin
                got_r = i_m_tdata[$bits(t_result)-1:0];
                if (tick_results_due.size() == 0) begin
                    $display("%0t: result with none due, got %h", $time, got_r);
                    fails++;
                end else begin
                    want_r = tick_results_due.pop_front();
                    check_field("out_la", want_r.out_la, got_r.out_la);
                    check_field("out_ha", want_r.out_ha, got_r.out_ha);
                    check_field("out_watch", want_r.out_watch, got_r.out_watch);
                    check_field("coin_accepted", want_r.coin_accepted, got_r.coin_accepted);
                    check_field("hack_seen", want_r.hack_seen, got_r.hack_seen);
                    check_field("coin_total", want_r.coin_total, got_r.coin_total);
                    check_field("hack_total", want_r.hack_total, got_r.hack_total);
                end
            end
            // predict each accepted request
            if (i_s_tvalid && i_s_tready) begin
                qualify_tick(i_s_tdata[0], i_s_tdata[REQ_W:1], want_r);
                tick_results_due.push_back(want_r);
            end
        end
        o_due_count  <= tick_results_due.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/tb_coin_pulse_qualifier_emitter.sv
// Testbench top for the coin pulse qualifier: clock, reset, stimulus, stalls and verdict.
module tb_coin_pulse_qualifier_emitter;
    import cpq_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 5000;
    localparam int unsigned HOLD_CYCLES = 300;

    // Indexes past the six registers
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum {REQ_NONE, REQ_SPARSE, REQ_MIXED, REQ_FLOOD} t_req_mode;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;   // [0] coin_in, [4:1] coin_request
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;          // [0] out_la, [1] out_ha, [2] out_watch,
                                               // [3] coin_accepted, [4] hack_seen,
                                               // [36:5] coin_total, [68:37] hack_total
    logic [31:0]           due_count;
    logic [31:0]           fail_count;

    // Current settings, used to shape pulses around the width window
    logic [MS_W-1:0]       cur_wmin  = RST_WIDTH_MIN;
    logic [MS_W-1:0]       cur_wmax  = RST_WIDTH_MAX;
    logic [MS_W-1:0]       cur_gap   = RST_HACK_GAP;
    logic                  cur_level = RST_START_LEVEL;
    int unsigned           burst_left = 0;
    int unsigned           ticks_left = 0;

    coin_pulse_qualifier_emitter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    cpq_tick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_due_count  (due_count),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offer one tick request; open a new burst after a random gap when the last one ran out
    task automatic send_tick(input logic coin_in, input logic [REQ_W-1:0] req);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_W'({req, coin_in});
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
    endtask

    // Drop the request and hold until every result is back
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (due_count != 0);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [MS_W-1:0] wmin, input logic [MS_W-1:0] wmax,
                             input logic [MS_W-1:0] gap, input logic [MS_W-1:0] emit,
                             input logic lvl, input logic [BLANK_W-1:0] blank,
                             input logic poke_spare);
        wait_idle();
        write_reg(CFG_WIDTH_MIN, CFG_DATA_W'(wmin));
        write_reg(CFG_WIDTH_MAX, CFG_DATA_W'(wmax));
        write_reg(CFG_HACK_GAP, CFG_DATA_W'(gap));
        write_reg(CFG_EMIT_PERIOD, CFG_DATA_W'(emit));
        write_reg(CFG_START_LEVEL, CFG_DATA_W'(lvl));
        write_reg(CFG_BLANK, CFG_DATA_W'(blank));
        if (poke_spare) begin
            write_reg(CFG_SPARE_LO, '1);
            write_reg(CFG_SPARE_HI, '1);
        end
        i_cfg_we  <= 1'b0;
        cur_wmin  = wmin;
        cur_wmax  = wmax;
        cur_gap   = gap;
        cur_level = lvl;
    endtask

    function automatic logic [REQ_W-1:0] pick_req(input t_req_mode mode);
        case (mode)
            REQ_NONE:   return '0;
            REQ_SPARSE: return ($urandom_range(0, 15) == 0) ? REQ_W'($urandom_range(0, 15)) : '0;
            REQ_MIXED:  return REQ_W'($urandom_range(0, 15));
            default:    return ($urandom_range(0, 63) == 0) ? REQ_W'($urandom_range(0, 15)) : '1;
        endcase
    endfunction

    task automatic hold_for(input logic lvl, input int unsigned len, input t_req_mode mode);
        repeat (len) begin
            if (ticks_left != 0) begin
                send_tick(lvl, pick_req(mode));
                ticks_left--;
            end
        end
    endtask

    // Mostly well-formed pulses near the width window and gap limit, some pin noise
    task automatic run_pulses(input int unsigned n, input t_req_mode mode);
        int unsigned lo;
        int unsigned hi;
        int unsigned rest;
        ticks_left = n;
        while (ticks_left != 0) begin
            if ($urandom_range(0, 4) != 0) begin
                rest = (cur_gap + 10 > 60) ? 60 : cur_gap + 10;
                hold_for(~cur_level, $urandom_range(1, rest), mode);
                lo = (cur_wmin > 2) ? cur_wmin - 1 : 1;
                hi = (cur_wmax + 2 > 60) ? 60 : cur_wmax + 2;
                if (lo > hi) begin
                    lo = hi;
                end
                hold_for(cur_level, $urandom_range(lo, hi), mode);
            end else begin
                repeat ($urandom_range(1, 6)) hold_for(1'($urandom_range(0, 1)), 1, mode);
            end
        end
    endtask

    // Result side: randomly redrawn stall patterns, with two long hold-offs
    initial begin : result_sink
        int unsigned rcyc;
        int unsigned mode;
        rcyc = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            rcyc++;
            if (rcyc % 128 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (rcyc == 1500 || rcyc == 5000) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= (rcyc % 4 != 3);
                    2:       i_m_tready <= 1'($urandom_range(0, 1));
                    default: i_m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // End the run when no request moves on either side for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [MS_W-1:0] rnd_wmin;
        logic [MS_W-1:0] rnd_wmax;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // during the startup blank: edges ignored, requests and timer still run
        send_tick(1'b1, 4'd15);
        send_tick(1'b0, 4'd0);
        send_tick(1'b1, 4'd1);
        send_tick(1'b0, 4'd8);
        send_tick(1'b1, 4'd2);
        send_tick(1'b1, 4'd4);

        // widest window, every start a hack, zero period, start level flipped to high
        configure(10'd0, 10'd1023, 10'd1023, 10'd0, 1'b1, 12'd0, 1'b1);
        send_tick(1'b1, 4'd0);
        send_tick(1'b0, 4'd0);
        send_tick(1'b1, 4'd0);
        send_tick(1'b0, 4'd0);
        send_tick(1'b0, 4'd15);
        send_tick(1'b1, 4'd0);
        send_tick(1'b1, 4'd0);
        send_tick(1'b0, 4'd0);

        // empty window, no hack gap, longest period
        configure(10'd1023, 10'd0, 10'd0, 10'd1023, 1'b0, 12'd0, 1'b0);
        send_tick(1'b1, 4'd0);
        send_tick(1'b0, 4'd0);
        send_tick(1'b1, 4'd0);
        send_tick(1'b0, 4'd3);
        send_tick(1'b1, 4'd0);

        // random phases
        configure(10'd3, 10'd12, 10'd20, 10'd5, 1'b0, 12'd100, 1'b0);
        run_pulses(250, REQ_NONE);
        configure(10'd10, 10'd11, 10'd0, 10'd1023, 1'b1, 12'd4095, 1'b0);
        run_pulses(120, REQ_SPARSE);
        configure(10'd2, 10'd30, 10'd1023, 10'd2, 1'b0, 12'd0, 1'b0);
        run_pulses(250, REQ_SPARSE);
        rnd_wmin = MS_W'($urandom_range(0, 15));
        rnd_wmax = MS_W'($urandom_range(rnd_wmin, 45));
        configure(rnd_wmin, rnd_wmax, MS_W'($urandom_range(0, 40)),
                  MS_W'($urandom_range(1, 8)), 1'($urandom_range(0, 1)),
                  BLANK_W'($urandom_range(0, 1200)), 1'b0);
        run_pulses(250, REQ_MIXED);
        // flood the toggle queue with a long period so it runs deep
        configure(10'd5, 10'd25, 10'd15, 10'd1023, 1'b1, 12'd2000, 1'b0);
        run_pulses(1000, REQ_FLOOD);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
